// ----- design/sld_pkg.sv -----
// shared constants, types and pointer arithmetic for the start/length/end deframer
// no dependencies
`default_nettype none

package sld_pkg;

    localparam int WINDOW_DEPTH = 512;
    localparam int PTR_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = $clog2(2 * WINDOW_DEPTH);

    localparam int BYTE_W = 8;
    localparam int DROP_W = 16;
    localparam int CFG_IDX_W = 1;

    // start marker, length byte and end marker
    localparam int FRAME_OVERHEAD = 3;

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h1F;
    localparam logic [BYTE_W-1:0] END_MARKER_RST = 8'h0A;

    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER = 1'b1;

    localparam logic KIND_PUSH = 1'b0;

    typedef enum logic [2:0] {
        EV_ACCEPTED = 3'd0,
        EV_OVERFLOW = 3'd1,
        EV_WAITING  = 3'd2,
        EV_DROPPED  = 3'd3,
        EV_FRAME    = 3'd4,
        EV_PAYLOAD  = 3'd5
    } t_event;

    // circular window address: base + off, where base + off < 2 * depth
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] base,
                                                  input logic [SUM_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + off;
        if (s >= SUM_W'(WINDOW_DEPTH)) begin
            s = s - SUM_W'(WINDOW_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- design/sld_ram.sv -----
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module sld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    parameter int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- design/start_length_end_deframer_top.sv -----
// start/length/end frame deframer: window ram, scan sequencer and result register
// depends on sld_pkg and sld_ram
//
// usage:
// - input channel (i_in_valid / o_in_ready) carries one item: i_kind 0 pushes
//   i_rx_byte into the window, i_kind 1 polls one scan action at the window head
// - output channel (o_out_valid / i_out_ready) returns exactly one result per item
// - config port: i_cfg_we writes i_cfg_data to start marker (index 0) or end
//   marker (index 1); write only while no item is in flight
// - a push finishes in the cycle it is accepted; its result shows in the cycle after
// - a poll on an empty window answers like a push; any other poll walks the scan
//   states: the window ram has one read port with a registered read, and a scan
//   reads head byte, length byte and terminator in turn;
//   a payload poll reads only the head byte
// - pushes run back to back at one item per cycle while the receiver takes results
// - the result register lets the next item be accepted in the cycle the current
//   result is taken; a stalled receiver holds the result and o_in_ready stays low
// - reset clears pointers, fill count, frame state, drop counter, result valid flag;
//   markers to defaults; window contents are not cleared and need no clearing pass
`default_nettype none

module start_length_end_deframer_top
    import sld_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_kind,
    input  wire logic [BYTE_W-1:0]    i_rx_byte,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic      [2:0]           o_event_res,
    output logic      [BYTE_W-1:0]    o_data,
    output logic                      o_last,
    output logic      [DROP_W-1:0]    o_dropped_count,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [BYTE_W-1:0]    i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_HEAD = 5'b00010,
        S_LEN  = 5'b00100,
        S_TERM = 5'b01000,
        S_PAY  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [CNT_W-1:0]   r_fill, n_fill;
    logic               r_emit, n_emit;
    logic [BYTE_W-1:0]  r_rem, n_rem;
    logic [BYTE_W-1:0]  r_len, n_len;
    logic [DROP_W-1:0]  r_drop, n_drop;
    logic [BYTE_W-1:0]  r_start, r_end;

    logic               r_out_valid;
    t_event             r_ev;
    logic [BYTE_W-1:0]  r_data;
    logic               r_last;

    logic               take;
    logic               out_free;
    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr;
    logic [BYTE_W-1:0]  rd_data;
    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic               res_fire;
    t_event             res_ev;
    logic [BYTE_W-1:0]  res_data;
    logic               res_last;

    function automatic logic [CNT_W-1:0] fill_sub(input logic [CNT_W-1:0] f,
                                                  input logic [CNT_W-1:0] n);
        return (f >= n) ? f - n : '0;
    endfunction

    sld_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(WINDOW_DEPTH)
    ) u_window (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(wr_addr),
        .i_wdata(i_rx_byte),
        .i_re   (rd_en),
        .i_raddr(rd_addr),
        .o_rdata(rd_data)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign take       = i_in_valid && o_in_ready;
    assign wr_addr    = ptr_add(r_head, SUM_W'(r_fill));

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_fill   = r_fill;
        n_emit   = r_emit;
        n_rem    = r_rem;
        n_len    = r_len;
        n_drop   = r_drop;
        rd_en    = 1'b0;
        rd_addr  = r_head;
        wr_en    = 1'b0;
        res_fire = 1'b0;
        res_ev   = EV_WAITING;
        res_data = '0;
        res_last = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (take) begin
                    if (i_kind == KIND_PUSH) begin
                        res_fire = 1'b1;
                        if (r_fill == CNT_W'(WINDOW_DEPTH)) begin
                            res_ev = EV_OVERFLOW;
                        end else begin
                            wr_en  = 1'b1;
                            n_fill = r_fill + CNT_W'(1);
                            res_ev = EV_ACCEPTED;
                        end
                    end else if (r_emit) begin
                        rd_en   = 1'b1;
                        n_state = S_PAY;
                    end else if (r_fill == '0) begin
                        res_fire = 1'b1;
                        res_ev   = EV_WAITING;
                    end else begin
                        rd_en   = 1'b1;
                        n_state = S_HEAD;
                    end
                end
            end
            S_PAY: begin
                res_fire = 1'b1;
                res_ev   = EV_PAYLOAD;
                res_data = rd_data;
                n_rem    = r_rem - BYTE_W'(1);
                n_state  = S_IDLE;
                if (r_rem == BYTE_W'(1)) begin
                    // terminator leaves with the last payload byte
                    res_last = 1'b1;
                    n_emit   = 1'b0;
                    n_head   = ptr_add(r_head, SUM_W'(2));
                    n_fill   = fill_sub(r_fill, CNT_W'(2));
                end else begin
                    n_head = ptr_add(r_head, SUM_W'(1));
                    n_fill = fill_sub(r_fill, CNT_W'(1));
                end
            end
            S_HEAD: begin
                if (rd_data != r_start) begin
                    res_fire = 1'b1;
                    res_ev   = EV_DROPPED;
                    n_head   = ptr_add(r_head, SUM_W'(1));
                    n_fill   = fill_sub(r_fill, CNT_W'(1));
                    n_drop   = (r_drop == '1) ? r_drop : r_drop + DROP_W'(1);
                    n_state  = S_IDLE;
                end else if (r_fill < CNT_W'(FRAME_OVERHEAD)) begin
                    res_fire = 1'b1;
                    res_ev   = EV_WAITING;
                    n_state  = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = ptr_add(r_head, SUM_W'(1));
                    n_state = S_LEN;
                end
            end
            S_LEN: begin
                n_len = rd_data;
                if ({1'b0, r_fill} <
                    (CNT_W + 1)'(rd_data) + (CNT_W + 1)'(FRAME_OVERHEAD)) begin
                    res_fire = 1'b1;
                    res_ev   = EV_WAITING;
                    n_state  = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = ptr_add(r_head, SUM_W'(rd_data) + SUM_W'(2));
                    n_state = S_TERM;
                end
            end
            S_TERM: begin
                res_fire = 1'b1;
                n_state  = S_IDLE;
                if (rd_data != r_end) begin
                    // drop only the start byte so the scan can resync
                    res_ev = EV_DROPPED;
                    n_head = ptr_add(r_head, SUM_W'(1));
                    n_fill = fill_sub(r_fill, CNT_W'(1));
                    n_drop = (r_drop == '1) ? r_drop : r_drop + DROP_W'(1);
                end else begin
                    res_ev   = EV_FRAME;
                    res_data = r_len;
                    if (r_len == '0) begin
                        n_head = ptr_add(r_head, SUM_W'(3));
                        n_fill = fill_sub(r_fill, CNT_W'(3));
                    end else begin
                        n_head = ptr_add(r_head, SUM_W'(2));
                        n_fill = fill_sub(r_fill, CNT_W'(2));
                        n_emit = 1'b1;
                        n_rem  = r_len;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_emit      <= 1'b0;
            r_rem       <= '0;
            r_drop      <= '0;
            r_start     <= START_MARKER_RST;
            r_end       <= END_MARKER_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fill  <= n_fill;
            r_emit  <= n_emit;
            r_rem   <= n_rem;
            r_drop  <= n_drop;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_START_MARKER: begin
                        r_start <= i_cfg_data;
                    end
                    REG_END_MARKER: begin
                        r_end <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (res_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload and length latch
    always_ff @(posedge i_clk) begin
        r_len <= n_len;
        if (res_fire) begin
            r_ev   <= res_ev;
            r_data <= res_data;
            r_last <= res_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_res     = r_ev;
    assign o_data          = r_data;
    assign o_last          = r_last;
    // drop counter only moves when a result is loaded, so it matches the held item
    assign o_dropped_count = r_drop;

endmodule

`default_nettype wire

// ----- design/sld_checker.sv -----
// port-level checks for the deframer top, attached by bind
// depends on sld_pkg
`default_nettype none

module sld_checker
    import sld_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_in_ready,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire logic [2:0]           o_event_res,
    input wire logic [BYTE_W-1:0]    o_data,
    input wire logic                 o_last,
    input wire logic [DROP_W-1:0]    o_dropped_count
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_event_res)
            && $stable(o_data) && $stable(o_last))
        else $error("result changed while stalled");

    // no new item while a result is stuck
    a_no_take_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("item taken while output stalled");

    a_last_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_event_res == EV_PAYLOAD)
        else $error("last flag on non-payload result");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res == EV_ACCEPTED || o_event_res == EV_OVERFLOW
            || o_event_res == EV_WAITING || o_event_res == EV_DROPPED) |-> o_data == '0)
        else $error("data nonzero on status result");

    a_drop_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> o_dropped_count >= $past(o_dropped_count))
        else $error("drop count decreased");

endmodule

bind start_length_end_deframer_top sld_checker u_sld_checker (.*);

`default_nettype wire

// ----- tb/sv/start_length_end_deframer_top_tb.sv -----
// testbench for start_length_end_deframer_top: streams framed and noisy bytes, polls the
// window and checks every result against a scoreboard that models the deframer
// depends on sld_pkg and the design sources

typedef struct packed {
    sld_pkg::t_event ev;
    logic [7:0]      data;
    logic            last;
    logic [15:0]     drops;
} t_deframe_outcome;

class deframer_scoreboard;
    logic [7:0]       ring [sld_pkg::WINDOW_DEPTH];
    int unsigned      rd_ptr;
    int unsigned      level;
    bit               in_payload;
    int unsigned      bytes_left;
    int unsigned      drop_total;
    logic [7:0]       start_mk;
    logic [7:0]       end_mk;
    sld_pkg::t_event  latest_ev;
    t_deframe_outcome due_outcomes [$];
    int unsigned      errors;
    int unsigned      seen [6];

    function new();
        rd_ptr = 0;
        level = 0;
        in_payload = 1'b0;
        bytes_left = 0;
        drop_total = 0;
        start_mk = sld_pkg::START_MARKER_RST;
        end_mk = sld_pkg::END_MARKER_RST;
        latest_ev = sld_pkg::EV_WAITING;
        errors = 0;
        foreach (seen[i]) seen[i] = 0;
    endfunction

    function void set_marker(logic [sld_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
        if (idx == sld_pkg::REG_START_MARKER) begin
            start_mk = val;
        end else if (idx == sld_pkg::REG_END_MARKER) begin
            end_mk = val;
        end
    endfunction

    function logic [7:0] peek(int unsigned off);
        return ring[(rd_ptr + off) % sld_pkg::WINDOW_DEPTH];
    endfunction

    function void retire(int unsigned n);
        rd_ptr = (rd_ptr + n) % sld_pkg::WINDOW_DEPTH;
        level = (level >= n) ? level - n : 0;
    endfunction

    function void drop_head();
        retire(1);
        if (drop_total < 16'hFFFF) drop_total++;
    endfunction

    function int unsigned pending();
        return due_outcomes.size();
    endfunction

    // works out the result of one accepted item and queues it
    function void absorb_item(logic kind, logic [7:0] rx);
        t_deframe_outcome r;
        int unsigned len;
        r.ev = sld_pkg::EV_WAITING;
        r.data = '0;
        r.last = 1'b0;
        if (kind == sld_pkg::KIND_PUSH) begin
            if (level >= sld_pkg::WINDOW_DEPTH) begin
                r.ev = sld_pkg::EV_OVERFLOW;
            end else begin
                ring[(rd_ptr + level) % sld_pkg::WINDOW_DEPTH] = rx;
                level++;
                r.ev = sld_pkg::EV_ACCEPTED;
            end
        end else if (in_payload) begin
            r.ev = sld_pkg::EV_PAYLOAD;
            r.data = peek(0);
            retire(1);
            if (bytes_left > 0) bytes_left--;
            if (bytes_left == 0) begin
                // terminator leaves with the final payload byte
                r.last = 1'b1;
                in_payload = 1'b0;
                retire(1);
            end
        end else if (level != 0 && peek(0) != start_mk) begin
            drop_head();
            r.ev = sld_pkg::EV_DROPPED;
        end else if (level >= sld_pkg::FRAME_OVERHEAD) begin
            len = peek(1);
            if (level >= len + sld_pkg::FRAME_OVERHEAD) begin
                if (peek(len + 2) != end_mk) begin
                    // resync: only the start byte goes
                    drop_head();
                    r.ev = sld_pkg::EV_DROPPED;
                end else begin
                    r.ev = sld_pkg::EV_FRAME;
                    r.data = len[7:0];
                    if (len == 0) begin
                        retire(sld_pkg::FRAME_OVERHEAD);
                    end else begin
                        retire(2);
                        in_payload = 1'b1;
                        bytes_left = len;
                    end
                end
            end
        end
        // anything not handled above leaves the poll waiting
        r.drops = drop_total[15:0];
        latest_ev = r.ev;
        due_outcomes = {due_outcomes, r};
    endfunction

    function void flag(string field, logic [15:0] want, logic [15:0] got);
        errors++;
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
    endfunction

    function void compare_outcome(logic [2:0] ev, logic [7:0] data, logic last,
                                  logic [15:0] drops);
        t_deframe_outcome want;
        if (due_outcomes.size() == 0) begin
            errors++;
            $error("result with no item waiting: event_res %0d", ev);
            return;
        end
        want = due_outcomes.pop_front();
        seen[int'(want.ev)]++;
        if (ev !== want.ev) flag("event_res", want.ev, ev);
        if (data !== want.data) flag("data", want.data, data);
        if (last !== want.last) flag("last", want.last, last);
        if (drops !== want.drops) flag("dropped_count", want.drops, drops);
    endfunction
endclass

module start_length_end_deframer_top_tb;
    import sld_pkg::*;

    localparam logic        KIND_POLL = 1'b1;
    localparam int unsigned CYCLE_LIMIT = 400_000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned RANDOM_PER_SETTING = 100;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 in_kind = 1'b0;
    logic [BYTE_W-1:0]    in_byte = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [2:0]           event_res;
    logic [BYTE_W-1:0]    data;
    logic                 last;
    logic [DROP_W-1:0]    dropped_count;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [BYTE_W-1:0]    cfg_data = '0;

    deframer_scoreboard sb;
    logic [7:0]         planned [$];
    bit                 hold_req = 1'b0;
    bit                 tx_gaps_on = 1'b1;
    bit                 rx_gaps_on = 1'b1;
    int unsigned        tx_mode_left = 0;
    int unsigned        rx_mode_left = 0;
    int unsigned        stall_left = 0;
    int unsigned        hold_left = 0;
    int unsigned        items_sent = 0;
    int unsigned        cycles = 0;

    start_length_end_deframer_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_kind          (in_kind),
        .i_rx_byte       (in_byte),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_event_res     (event_res),
        .o_data          (data),
        .o_last          (last),
        .o_dropped_count (dropped_count),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("start_length_end_deframer_top test failed");
            $finish;
        end
    end

    // result side: random stalls per item, plus one long hold-off on request
    always @(negedge clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left != 0) begin
            out_ready = 1'b0;
            hold_left--;
        end else if (stall_left != 0) begin
            out_ready = 1'b0;
            stall_left--;
        end else begin
            out_ready = 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            sb.compare_outcome(event_res, data, last, dropped_count);
            if (rx_mode_left == 0) begin
                rx_gaps_on = $urandom_range(0, 1);
                rx_mode_left = $urandom_range(16, 48);
            end
            rx_mode_left--;
            stall_left = (!rx_gaps_on) ? 0 : $urandom_range(0, 8);
        end
    end

    task automatic send_item(input logic k, input logic [7:0] b);
        int unsigned gap;
        if (tx_mode_left == 0) begin
            tx_gaps_on = $urandom_range(0, 1);
            tx_mode_left = $urandom_range(16, 48);
        end
        tx_mode_left--;
        gap = (!tx_gaps_on) ? 0 : $urandom_range(0, 8);
        @(negedge clk);
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_kind = k;
        in_byte = b;
        do @(posedge clk); while (!in_ready);
        sb.absorb_item(k, b);
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
    endtask

    task automatic write_marker(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_marker(idx, val);
    endtask

    // mostly well-formed frames with random payload, some bad terminators and noise
    function automatic void plan_sequence();
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(0, 99);
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
        if (pick < 90) begin
            planned = {planned, sb.start_mk};
            planned = {planned, len[7:0]};
            repeat (len) planned = {planned, 8'($urandom)};
            planned = {planned,
                       (pick < 78) ? sb.end_mk : sb.end_mk ^ 8'($urandom_range(1, 255))};
        end else begin
            repeat ($urandom_range(1, 4)) planned = {planned, 8'($urandom)};
        end
    endfunction

    function automatic logic [7:0] next_stream_byte();
        if (planned.size() == 0) plan_sequence();
        return planned.pop_front();
    endfunction

    task automatic run_random(input int unsigned n);
        int unsigned poll_pct;
        repeat (n) begin
            poll_pct = (sb.level > 300) ? 80 : (sb.in_payload ? 55 : 40);
            if ($urandom_range(0, 99) < poll_pct) begin
                send_item(KIND_POLL, 8'($urandom));
            end else begin
                send_item(KIND_PUSH, next_stream_byte());
            end
        end
    endtask

    // a frame stuck waiting at the head gets fed noise until it resolves
    task automatic empty_window();
        while (sb.level != 0) begin
            if (sb.latest_ev == EV_WAITING) begin
                send_item(KIND_PUSH, 8'($urandom));
            end else begin
                send_item(KIND_POLL, 8'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        logic [7:0]  s_mk;
        logic [7:0]  e_mk;
        sb = new();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        send_item(KIND_POLL, 8'h00);              // empty window waits
        send_item(KIND_PUSH, 8'h00);
        send_item(KIND_POLL, 8'hFF);              // non-start byte dropped
        send_item(KIND_PUSH, START_MARKER_RST);
        send_item(KIND_POLL, 8'h00);              // marker alone waits
        send_item(KIND_PUSH, 8'h00);
        send_item(KIND_PUSH, 8'hFF);
        send_item(KIND_POLL, 8'h00);              // bad terminator, marker alone dropped
        send_item(KIND_POLL, 8'h00);
        send_item(KIND_POLL, 8'h00);
        send_item(KIND_PUSH, START_MARKER_RST);
        send_item(KIND_PUSH, 8'h00);
        send_item(KIND_PUSH, END_MARKER_RST);
        send_item(KIND_POLL, 8'h00);              // empty frame
        send_item(KIND_PUSH, START_MARKER_RST);
        send_item(KIND_PUSH, 8'h02);
        send_item(KIND_PUSH, 8'hFF);
        send_item(KIND_POLL, 8'h00);              // partial frame waits
        send_item(KIND_PUSH, 8'h00);
        send_item(KIND_PUSH, END_MARKER_RST);
        send_item(KIND_POLL, 8'h00);              // two-byte frame found
        send_item(KIND_PUSH, 8'h5A);              // push while emitting
        send_item(KIND_POLL, 8'h00);
        drain_results();
        // new markers must not disturb the frame being delivered
        write_marker(REG_START_MARKER, 8'h5A);
        write_marker(REG_END_MARKER, 8'h00);
        send_item(KIND_POLL, 8'h00);
        send_item(KIND_POLL, 8'h00);

        for (int p = 0; p < 5; p++) begin
            drain_results();
            case (p)
                0: begin
                    s_mk = 8'h00;
                    e_mk = 8'hFF;
                end
                1: begin
                    s_mk = 8'hFF;
                    e_mk = 8'h00;
                end
                2: begin
                    s_mk = 8'h7E;
                    e_mk = 8'h7E;
                end
                3: begin
                    s_mk = 8'($urandom);
                    e_mk = 8'($urandom);
                end
                default: begin
                    s_mk = START_MARKER_RST;
                    e_mk = END_MARKER_RST;
                end
            endcase
            write_marker(REG_START_MARKER, s_mk);
            write_marker(REG_END_MARKER, e_mk);
            run_random(RANDOM_PER_SETTING);
        end

        // fill to overflow while results back up behind a long receiver hold-off
        drain_results();
        send_item(KIND_PUSH, next_stream_byte());
        hold_req = 1'b1;
        while (sb.level < WINDOW_DEPTH) send_item(KIND_PUSH, next_stream_byte());
        repeat (3) send_item(KIND_PUSH, 8'($urandom));
        empty_window();

        // short random tail with the reset markers
        drain_results();
        run_random(60);

        drain_results();
        repeat (8) @(posedge clk);
        $display("%0d items sent: %0d pushes taken, %0d overflows, %0d waits, %0d drops",
                 items_sent, sb.seen[EV_ACCEPTED], sb.seen[EV_OVERFLOW],
                 sb.seen[EV_WAITING], sb.seen[EV_DROPPED]);
        $display("%0d frames, %0d payload bytes, drop count ended at %0d",
                 sb.seen[EV_FRAME], sb.seen[EV_PAYLOAD], sb.drop_total);
        if (sb.errors == 0) begin
            $display("start_length_end_deframer_top test passed");
        end else begin
            $display("start_length_end_deframer_top test failed");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
design/sld_pkg.sv
design/sld_ram.sv
design/start_length_end_deframer_top.sv
design/sld_checker.sv
tb/sv/start_length_end_deframer_top_tb.sv
